FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL files; iac_back includes them.
// Each macro expects clk and arst_n to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/iac_pkg.sv
// ----------------------------------------------------------------------------
// iac_pkg
// Types, constants and helper functions for the initial attitude block.
// ----------------------------------------------------------------------------
package iac_pkg;

	// Output fraction bits and the shift that rounds Q60 products to it
	localparam int FRAC_BITS = 14;
	localparam int RND_SH    = 60 - FRAC_BITS;

	// One in Q30
	localparam logic signed [31:0] ONE30 = 32'sh4000_0000;

	// Register reset values
	localparam logic [14:0] ACC_MIN_RST = 15'd8192;
	localparam logic [15:0] MAG_MIN_RST = 16'd200;
	localparam logic [15:0] MAG_MAX_RST = 16'd600;

	// Register indexes
	localparam logic [1:0] REG_ACC_MIN = 2'd0;
	localparam logic [1:0] REG_MAG_MIN = 2'd1;
	localparam logic [1:0] REG_MAG_MAX = 2'd2;

	// Queue between front and back (power of two)
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	typedef struct packed {
		logic signed [15:0] acc_x;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_z;
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
		logic signed [15:0] mag_z;
	} iac_in_t;

	typedef struct packed {
		logic signed [15:0] q_w;
		logic signed [15:0] q_x;
		logic signed [15:0] q_y;
		logic signed [15:0] q_z;
		logic               tilt_ok;
		logic               heading_ok;
		logic               all_ok;
	} iac_out_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               az_neg;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic [31:0]        sa;
		logic [31:0]        gh;
		logic               tilt;
		logic               head;
	} iac_item_t;

	// Square root unit request
	typedef struct packed {
		logic        start;
		logic [63:0] rad;
	} iac_sq_req_t;

	// Divider request: unsigned numerator, divisor
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} iac_dv_req_t;

	// Shared response of the iterative units
	typedef struct packed {
		logic        done;
		logic [31:0] val;
	} iac_rsp_t;

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [30:0] sq16(input logic signed [15:0] v);
		logic signed [31:0] p;
		p = v * v;
		return p[30:0];
	endfunction

	// Round a Q60 value to Q.FRAC_BITS, half away from zero, then saturate
	function automatic logic [15:0] out_comp(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] lim;
		m   = x[63] ? 64'(-x) : 64'(x);
		q   = (m + (64'd1 << (RND_SH - 1))) >> RND_SH;
		lim = 64'd1 << FRAC_BITS;
		if (q > lim) q = lim;
		if (!x[63] && q > 64'd32767) q = 64'd32767;
		if (x[63] && q > 64'd32768) q = 64'd32768;
		return x[63] ? 16'(-q) : 16'(q);
	endfunction

endpackage

FILE: hdl/iac_front.sv
// ----------------------------------------------------------------------------
// iac_front
// Accepts samples, forms squared norms, checks them against the thresholds
// and pushes classified requests into the queue. Holds the config registers.
// ----------------------------------------------------------------------------
module iac_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  iac_pkg::iac_in_t    in_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata,
	input  logic                q_full,
	output logic                q_push,
	output iac_pkg::iac_item_t  q_data
);

	logic [14:0] amin_q;
	logic [15:0] mlo_q, mhi_q;
	logic [29:0] amin_sq_q;
	logic [31:0] mlo_sq_q, mhi_sq_q;

	logic               v_s1, v_s2;
	iac_pkg::iac_in_t   in_s1;
	logic [30:0]        sqax_s1, sqay_s1, sqaz_s1, sqmx_s1, sqmy_s1, sqmz_s1;
	iac_pkg::iac_item_t itm_s2;

	logic        en_s2, en_s1;
	logic [31:0] sa, gh, sm;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amin_q <= iac_pkg::ACC_MIN_RST;
			mlo_q  <= iac_pkg::MAG_MIN_RST;
			mhi_q  <= iac_pkg::MAG_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				iac_pkg::REG_ACC_MIN: amin_q <= cfg_wdata[14:0];
				iac_pkg::REG_MAG_MIN: mlo_q  <= cfg_wdata;
				iac_pkg::REG_MAG_MAX: mhi_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// squared thresholds, refreshed every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amin_sq_q <= 30'(iac_pkg::ACC_MIN_RST * iac_pkg::ACC_MIN_RST);
			mlo_sq_q  <= 32'(iac_pkg::MAG_MIN_RST * iac_pkg::MAG_MIN_RST);
			mhi_sq_q  <= 32'(iac_pkg::MAG_MAX_RST * iac_pkg::MAG_MAX_RST);
		end else begin
			amin_sq_q <= 30'(amin_q * amin_q);
			mlo_sq_q  <= 32'(mlo_q * mlo_q);
			mhi_sq_q  <= 32'(mhi_q * mhi_q);
		end
	end

	// pipeline flow
	assign q_push   = v_s2 && !q_full;
	assign en_s2    = !v_s2 || !q_full;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign q_data   = itm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: squares
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			in_s1   <= in_data;
			sqax_s1 <= iac_pkg::sq16(in_data.acc_x);
			sqay_s1 <= iac_pkg::sq16(in_data.acc_y);
			sqaz_s1 <= iac_pkg::sq16(in_data.acc_z);
			sqmx_s1 <= iac_pkg::sq16(in_data.mag_x);
			sqmy_s1 <= iac_pkg::sq16(in_data.mag_y);
			sqmz_s1 <= iac_pkg::sq16(in_data.mag_z);
		end
	end

	// stage 2: norms and checks
	assign sa = 32'(sqax_s1) + 32'(sqay_s1) + 32'(sqaz_s1);
	assign gh = 32'(sqmx_s1) + 32'(sqmy_s1);
	assign sm = gh + 32'(sqmz_s1);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			itm_s2.ax     <= in_s1.acc_x;
			itm_s2.ay     <= in_s1.acc_y;
			itm_s2.az     <= in_s1.acc_z;
			itm_s2.az_neg <= in_s1.acc_z[15];
			itm_s2.mx     <= in_s1.mag_x;
			itm_s2.my     <= in_s1.mag_y;
			itm_s2.sa     <= sa;
			itm_s2.gh     <= gh;
			itm_s2.tilt   <= sa > 32'(amin_sq_q);
			itm_s2.head   <= (sm > mlo_sq_q) && (sm < mhi_sq_q) && (gh != 32'd0);
		end
	end

endmodule

FILE: hdl/iac_fifo.sv
// ----------------------------------------------------------------------------
// iac_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module iac_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  iac_pkg::iac_item_t  wdata,
	output logic                full,
	input  logic                pop,
	output iac_pkg::iac_item_t  rdata,
	output logic                empty
);

	iac_pkg::iac_item_t           mem_q [iac_pkg::FQ_DEPTH];
	logic [iac_pkg::FQ_AW-1:0]    wp_q, rp_q;
	logic [iac_pkg::FQ_AW:0]      cnt_q;

	assign full  = cnt_q == (iac_pkg::FQ_AW+1)'(iac_pkg::FQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

FILE: hdl/iac_sqrt.sv
// ----------------------------------------------------------------------------
// iac_sqrt
// Integer square root of a 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module iac_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iac_pkg::iac_sq_req_t req,
	output iac_pkg::iac_rsp_t    rsp
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [33:0] rem_n, trial;
	logic        ge;

	assign rem_n = {rem_q[31:0], rad_q[63:62]};
	assign trial = {root_q, 2'b01};
	assign ge    = rem_n >= trial;

	assign rsp.done = done_q;
	assign rsp.val  = root_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: bring down two bits, try the next root bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? rem_n - trial : rem_n;
			root_q <= {root_q[30:0], ge};
		end
	end

endmodule

FILE: hdl/iac_div.sv
// ----------------------------------------------------------------------------
// iac_div
// Unsigned restoring divider with round half up: 32 quotient bits,
// one per cycle. The quotient must fit in 32 bits.
// ----------------------------------------------------------------------------
module iac_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iac_pkg::iac_dv_req_t req,
	output iac_pkg::iac_rsp_t    rsp
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q, lo_q, den_q, quo_q;
	logic [63:0] num_rnd;
	logic [32:0] rem_n;
	logic        ge;

	// add half the divisor up front for rounding
	assign num_rnd = req.num + {33'd0, req.den[31:1]};
	assign rem_n   = {rem_q, lo_q[31]};
	assign ge      = rem_n >= {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.val  = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_rnd[63:32];
			lo_q  <= num_rnd[31:0];
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem_n - {1'b0, den_q}) : rem_n[31:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

endmodule

FILE: hdl/iac_back.sv
// ----------------------------------------------------------------------------
// iac_back
// Sequencer that takes one request from the queue, runs the norm roots,
// unit divisions and half-angle steps on the shared units, forms the
// quaternion product and drives the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iac_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  iac_pkg::iac_item_t   q_data,
	output iac_pkg::iac_sq_req_t sq_req,
	input  iac_pkg::iac_rsp_t    sq_rsp,
	output iac_pkg::iac_dv_req_t dv_req,
	input  iac_pkg::iac_rsp_t    dv_rsp,
	output logic                 out_valid,
	input  logic                 out_stall,
	output iac_pkg::iac_out_t    out_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_RND   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [3:0] OP_ASQ = 4'd0;  // accel norm root
	localparam logic [3:0] OP_AUX = 4'd1;
	localparam logic [3:0] OP_AUY = 4'd2;
	localparam logic [3:0] OP_AUZ = 4'd3;
	localparam logic [3:0] OP_APL = 4'd4;  // tilt pole root
	localparam logic [3:0] OP_AS1 = 4'd5;
	localparam logic [3:0] OP_AS2 = 4'd6;
	localparam logic [3:0] OP_HSQ = 4'd7;  // horizontal field root
	localparam logic [3:0] OP_HC  = 4'd8;
	localparam logic [3:0] OP_HS  = 4'd9;
	localparam logic [3:0] OP_HPL = 4'd10; // heading pole root
	localparam logic [3:0] OP_HSD = 4'd11;

	logic [2:0] st_q;
	logic [3:0] op_q;
	logic [3:0] k_q;
	logic [1:0] r_q;
	logic       out_valid_q;
	logic       dneg_q;

	iac_pkg::iac_item_t itm_q;
	logic [31:0]        n_q, pa_q, pb_q;
	logic signed [31:0] ux_q, uy_q, uz_q, c_q, s_q, t1_q, t2_q, t3_q;
	logic signed [63:0] sum_q [4];
	logic [15:0]        comp_q [4];

	logic signed [63:0] prod_s1;
	logic [2:0]         term_s1;
	logic               tneg_s1;
	logic               pv_s1;

	logic               is_sqrt, load;
	logic [3:0]         op_first, op_next;
	logic [31:0]        qmag;
	logic signed [31:0] dres;
	logic [31:0]        pole_sum;
	logic [31:0]        ux_abs, uy_abs, s_abs;
	logic signed [31:0] aw, a1, a2, a3, bw, b3, mul_a, mul_b;
	logic               mul_neg;
	logic signed [63:0] addend;

	assign q_pop     = (st_q == ST_IDLE) && !q_empty;
	assign is_sqrt   = (op_q == OP_ASQ) || (op_q == OP_APL) ||
	                   (op_q == OP_HSQ) || (op_q == OP_HPL);
	assign load      = (st_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// first and following operations of a request
	assign op_first = q_data.tilt ? OP_ASQ : OP_HSQ;
	always_comb begin
		op_next = op_q + 1'b1;
		if (op_q == OP_AS2 && !itm_q.head) op_next = OP_HSD;
	end

	// signed, clamped division result
	assign qmag = (dv_rsp.val > 32'(iac_pkg::ONE30)) ? 32'(iac_pkg::ONE30) : dv_rsp.val;
	assign dres = dneg_q ? -$signed(qmag) : $signed(qmag);

	// magnitudes of the half-angle numerators
	assign ux_abs = iac_pkg::abs32(ux_q);
	assign uy_abs = iac_pkg::abs32(uy_q);
	assign s_abs  = iac_pkg::abs32(s_q);

	// unit operand selection
	always_comb begin
		sq_req.start = (st_q == ST_ISSUE) && is_sqrt;
		dv_req.start = (st_q == ST_ISSUE) && !is_sqrt;
		sq_req.rad   = '0;
		dv_req.num   = '0;
		dv_req.den   = n_q;
		pole_sum     = '0;
		unique case (op_q)
			OP_ASQ: sq_req.rad = {itm_q.sa, 32'd0};
			OP_HSQ: sq_req.rad = {itm_q.gh, 32'd0};
			OP_APL: begin
				pole_sum   = 32'(iac_pkg::ONE30) + iac_pkg::abs32(uz_q);
				sq_req.rad = {3'd0, pole_sum, 29'd0};
			end
			OP_HPL: begin
				pole_sum   = 32'(iac_pkg::ONE30) + iac_pkg::abs32(c_q);
				sq_req.rad = {3'd0, pole_sum, 29'd0};
			end
			OP_AUX: dv_req.num = {2'd0, iac_pkg::abs16(itm_q.ax), 46'd0};
			OP_AUY: dv_req.num = {2'd0, iac_pkg::abs16(itm_q.ay), 46'd0};
			OP_AUZ: dv_req.num = {2'd0, iac_pkg::abs16(itm_q.az), 46'd0};
			OP_HC:  dv_req.num = {2'd0, iac_pkg::abs16(itm_q.mx), 46'd0};
			OP_HS:  dv_req.num = {2'd0, iac_pkg::abs16(itm_q.my), 46'd0};
			OP_AS1: begin
				dv_req.num = {3'd0, uy_abs[30:0], 30'd0};
				dv_req.den = {pa_q[30:0], 1'b0};
			end
			OP_AS2: begin
				dv_req.num = {3'd0, ux_abs[30:0], 30'd0};
				dv_req.den = {pa_q[30:0], 1'b0};
			end
			OP_HSD: begin
				dv_req.num = {3'd0, s_abs[30:0], 30'd0};
				dv_req.den = {pb_q[30:0], 1'b0};
			end
			default: ;
		endcase
	end

	// quaternion parts from the chosen branches
	always_comb begin
		aw = iac_pkg::ONE30;
		a1 = '0;
		a2 = '0;
		a3 = '0;
		bw = iac_pkg::ONE30;
		b3 = '0;
		if (itm_q.tilt) begin
			if (itm_q.az_neg) begin
				a1 = $signed(pa_q);
				aw = t1_q;
				a3 = t2_q;
			end else begin
				aw = $signed(pa_q);
				a1 = t1_q;
				a2 = t2_q;
			end
		end
		if (itm_q.head) begin
			if (itm_q.mx[15]) begin
				b3 = $signed(pb_q);
				bw = t3_q;
			end else begin
				bw = $signed(pb_q);
				b3 = t3_q;
			end
		end
	end

	// product terms of conj(qa * qm), two per component
	always_comb begin
		mul_a   = aw;
		mul_b   = bw;
		mul_neg = 1'b0;
		unique case (k_q[2:0])
			3'd0: begin mul_a = aw; mul_b = bw; mul_neg = 1'b0; end
			3'd1: begin mul_a = a3; mul_b = b3; mul_neg = 1'b1; end
			3'd2: begin mul_a = a1; mul_b = bw; mul_neg = 1'b1; end
			3'd3: begin mul_a = a2; mul_b = b3; mul_neg = 1'b1; end
			3'd4: begin mul_a = a2; mul_b = bw; mul_neg = 1'b1; end
			3'd5: begin mul_a = a1; mul_b = b3; mul_neg = 1'b0; end
			3'd6: begin mul_a = aw; mul_b = b3; mul_neg = 1'b1; end
			3'd7: begin mul_a = a3; mul_b = bw; mul_neg = 1'b1; end
			default: ;
		endcase
	end

	assign addend = tneg_s1 ? -prod_s1 : prod_s1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			op_q        <= OP_ASQ;
			k_q         <= '0;
			r_q         <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pv_s1 <= (st_q == ST_MUL) && !k_q[3];
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						op_q <= op_first;
						k_q  <= '0;
						st_q <= (q_data.tilt || q_data.head) ? ST_ISSUE : ST_MUL;
					end
				end
				ST_ISSUE: st_q <= ST_WAIT;
				ST_WAIT: begin
					if ((is_sqrt && sq_rsp.done) || (!is_sqrt && dv_rsp.done)) begin
						if (op_q == OP_HSD || (op_q == OP_AS2 && !itm_q.head)) begin
							st_q <= ST_MUL;
						end else begin
							op_q <= op_next;
							st_q <= ST_ISSUE;
						end
					end
				end
				ST_MUL: begin
					if (k_q[3]) begin
						r_q  <= '0;
						st_q <= ST_RND;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_RND: begin
					r_q <= r_q + 1'b1;
					if (r_q == 2'd3) st_q <= ST_OUT;
				end
				ST_OUT: if (load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// request, intermediate values and products
	always_ff @(posedge clk) begin
		if (q_pop) itm_q <= q_data;
		if (st_q == ST_ISSUE) begin
			unique case (op_q)
				OP_AUX: dneg_q <= itm_q.ax[15];
				OP_AUY: dneg_q <= itm_q.ay[15];
				OP_AUZ: dneg_q <= itm_q.az[15];
				OP_HC:  dneg_q <= itm_q.mx[15];
				OP_HS:  dneg_q <= itm_q.my[15];
				OP_AS1: dneg_q <= !uy_q[31] && (uy_q != '0);
				OP_AS2: dneg_q <= ux_q[31];
				OP_HSD: dneg_q <= s_q[31];
				default: dneg_q <= 1'b0;
			endcase
		end
		if (st_q == ST_WAIT && sq_rsp.done) begin
			unique case (op_q)
				OP_APL: pa_q <= sq_rsp.val;
				OP_HPL: pb_q <= sq_rsp.val;
				default: n_q <= sq_rsp.val;
			endcase
		end
		if (st_q == ST_WAIT && dv_rsp.done) begin
			unique case (op_q)
				OP_AUX: ux_q <= dres;
				OP_AUY: uy_q <= dres;
				OP_AUZ: uz_q <= dres;
				OP_AS1: t1_q <= dres;
				OP_AS2: t2_q <= dres;
				OP_HC:  c_q  <= dres;
				OP_HS:  s_q  <= dres;
				default: t3_q <= dres;
			endcase
		end
		// multiply into a register, then accumulate the registered product
		prod_s1 <= mul_a * mul_b;
		term_s1 <= k_q[2:0];
		tneg_s1 <= mul_neg;
		if (pv_s1) begin
			sum_q[term_s1[2:1]] <= term_s1[0] ? sum_q[term_s1[2:1]] + addend : addend;
		end
		if (st_q == ST_RND) comp_q[r_q] <= iac_pkg::out_comp(sum_q[r_q]);
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_data.q_w        <= comp_q[0];
			out_data.q_x        <= comp_q[1];
			out_data.q_y        <= comp_q[2];
			out_data.q_z        <= comp_q[3];
			out_data.tilt_ok    <= itm_q.tilt;
			out_data.heading_ok <= itm_q.head;
			out_data.all_ok     <= itm_q.tilt && itm_q.head;
		end
	end

	`ASSERT_NEXT(a_rnd_to_out, (st_q == ST_RND) && (r_q == 2'd3), st_q == ST_OUT, "rounding did not end in output state")
	`ASSERT_IMPL(a_div_range, (st_q == ST_WAIT) && !is_sqrt && dv_rsp.done, dv_rsp.val <= 32'(iac_pkg::ONE30), "unit quotient above one")
	`ASSERT_IMPL(a_pole_range, (st_q == ST_WAIT) && sq_rsp.done && ((op_q == OP_APL) || (op_q == OP_HPL)), sq_rsp.val >= 32'h2000_0000, "pole root below half")

endmodule

FILE: hdl/initial_attitude_from_acc_mag_top.sv
// ----------------------------------------------------------------------------
// initial_attitude_from_acc_mag_top
// Initial attitude quaternion from one accelerometer and one magnetometer
// sample.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid/in_stall/in_data carries one sample request; the
//  output channel out_valid/out_stall/out_data returns one quaternion with
//  tilt, heading and combined validity flags per request, in order.
//  The front takes a request in any cycle that in_stall is low; it checks
//  the norms in two stages and queues up to four requests for the back.
//  The back runs one request at a time on a shared root unit and a shared
//  divider, with up to 12 calls for a full request, then forms the
//  products and rounds the four components. A request that fails both
//  checks skips the unit calls. The back takes a new request from the
//  queue only after the last result has been loaded into the output
//  register. Reset clears the queue, the sequencer and the output valid,
//  and loads the threshold registers with their defaults. While out_stall
//  is high the result is held; the back then waits, the queue fills, and
//  finally in_stall rises.
//  Config: cfg_we with cfg_idx 0 acc_norm_min, 1 mag_norm_min, 2 mag_norm_max.
// ----------------------------------------------------------------------------
module initial_attitude_from_acc_mag_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  iac_pkg::iac_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output iac_pkg::iac_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_wdata
);

	logic                 q_push, q_full, q_pop, q_empty;
	iac_pkg::iac_item_t   q_wdata, q_rdata;
	iac_pkg::iac_sq_req_t sq_req;
	iac_pkg::iac_dv_req_t dv_req;
	iac_pkg::iac_rsp_t    sq_rsp, dv_rsp;

	iac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	iac_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	iac_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	iac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dv_req),
		.rsp    (dv_rsp)
	);

	iac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_rdata),
		.sq_req    (sq_req),
		.sq_rsp    (sq_rsp),
		.dv_req    (dv_req),
		.dv_rsp    (dv_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
